// ===== src/ascii_to_unsigned_parser_defines.svh =====
// Assertion macros for the ASCII to unsigned parser.
// Needs no other file; included by the top level.
`ifndef ASCII_TO_UNSIGNED_PARSER_DEFINES_SVH
`define ASCII_TO_UNSIGNED_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define A2U_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("a2u assertion failed");
`define A2U_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("a2u assertion failed");
`else
`define A2U_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define A2U_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/a2u_pkg.sv =====
// Types, constants and character helpers for the ASCII to unsigned parser.
// Depends on nothing.
package a2u_pkg;

	localparam int WORD_BITS   = 32;
	localparam int OFFSET_BITS = 16;
	localparam int RADIX_BITS  = 6;
	localparam int WIDE_BITS   = WORD_BITS + RADIX_BITS;

	localparam logic [RADIX_BITS-1:0] RADIX_AUTO = 6'd0;
	localparam logic [RADIX_BITS-1:0] RADIX_ONE  = 6'd1;
	localparam logic [RADIX_BITS-1:0] RADIX_MIN  = 6'd2;
	localparam logic [RADIX_BITS-1:0] RADIX_OCT  = 6'd8;
	localparam logic [RADIX_BITS-1:0] RADIX_DEC  = 6'd10;
	localparam logic [RADIX_BITS-1:0] RADIX_HEX  = 6'd16;
	localparam logic [RADIX_BITS-1:0] RADIX_MAX  = 6'd36;
	localparam logic [RADIX_BITS-1:0] DIGIT_NONE = 6'd63;

	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_UA_OFF = 8'd55;  // 'A' - 10
	localparam logic [7:0] CH_LA_OFF = 8'd87;  // 'a' - 10
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_LX     = 8'h78;
	localparam logic [7:0] CH_UX     = 8'h58;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SPACE,
		PH_SIGNED,
		PH_ZERO,
		PH_XSEEN,
		PH_DIGITS
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       first;
	} a2u_in_t;

	typedef struct packed {
		logic [WORD_BITS-1:0]   value;
		logic                   overflow;
		logic [OFFSET_BITS-1:0] stop_offset;
		logic                   any_digit;
	} a2u_out_t;

	function automatic logic [RADIX_BITS-1:0] digit_value(input logic [7:0] c);
		logic [RADIX_BITS-1:0] d;
		d = DIGIT_NONE;
		if (c >= CH_ZERO && c <= CH_NINE)
			d = RADIX_BITS'(c - CH_ZERO);
		else if (c >= CH_UA && c <= CH_UZ)
			d = RADIX_BITS'(c - CH_UA_OFF);
		else if (c >= CH_LA && c <= CH_LZ)
			d = RADIX_BITS'(c - CH_LA_OFF);
		return d;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

// ===== src/ascii_to_unsigned_parser.sv =====
// Streaming ASCII to unsigned integer parser, one character per cycle.
// Depends on a2u_pkg and ascii_to_unsigned_parser_defines.svh.
//
//  channel  | signals                        | moves
//  ---------+--------------------------------+------------------------------
//  input    | in_valid, in_stall, in_req     | one character and restart flag
//  output   | out_valid, out_stall, out_req  | value, overflow, offset, digit
//  config   | cfg_we, cfg_wdata              | radix, write only
//
// One character per cycle while in_stall is low; a result is registered in out_req_q
// from the req_s1 stage that holds the character that ends it.
// The critical path is the accumulator multiply-add by the base (32 x 6 bits).
// Reset clears the parse state and sets radix to automatic.
// An output stall holds back the input only when a character ending a parse
// finds the result register still full.
`include "ascii_to_unsigned_parser_defines.svh"

module ascii_to_unsigned_parser
	import a2u_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [RADIX_BITS-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  a2u_in_t               in_req,
	output logic                  out_valid,
	input  logic                  out_stall,
	output a2u_out_t              out_req
);

	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

	logic [RADIX_BITS-1:0]  radix_q;
	logic                   valid_s1;
	a2u_in_t                req_s1;

	phase_t                 phase_q, phase_c, phase_cur;
	logic [WORD_BITS-1:0]   acc_q, acc_c;
	logic [RADIX_BITS-1:0]  base_q, base_c;
	logic                   neg_q, neg_c;
	logic                   digit_q, digit_c;
	logic                   ovf_q, ovf_c;
	logic [OFFSET_BITS-1:0] idx_q, idx_c;

	logic                   emit, take, lead, take_ok;
	logic [RADIX_BITS-1:0]  dval;
	logic [WIDE_BITS-1:0]   prod;
	logic                   go;
	a2u_out_t               res_c;
	logic                   out_valid_q;
	a2u_out_t               out_req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radix_q <= RADIX_AUTO;
		else if (cfg_we)
			radix_q <= cfg_wdata;
	end

	// parse state update, next state and datapath
	always_comb begin
		phase_c = phase_q;
		acc_c   = acc_q;
		base_c  = base_q;
		neg_c   = neg_q;
		digit_c = digit_q;
		ovf_c   = ovf_q;
		idx_c   = idx_q;
		emit    = 1'b0;
		take    = 1'b0;
		lead    = 1'b0;
		take_ok = 1'b0;
		prod    = '0;
		dval    = digit_value(req_s1.ch);
		phase_cur = phase_q;

		if (req_s1.first) begin
			acc_c   = '0;
			neg_c   = 1'b0;
			digit_c = 1'b0;
			ovf_c   = 1'b0;
			idx_c   = '0;
			base_c  = (radix_q == RADIX_ONE) ? RADIX_DEC : radix_q;
			if (base_c > RADIX_MAX) begin
				phase_cur = PH_IDLE;
				emit      = 1'b1;
			end else begin
				phase_cur = PH_SPACE;
			end
		end
		phase_c = phase_cur;

		unique case (phase_cur)
			PH_SPACE: begin
				if (is_space(req_s1.ch)) begin
					idx_c = (idx_c == OFFSET_MAX) ? idx_c : idx_c + 1'b1;
				end else if (req_s1.ch == CH_MINUS || req_s1.ch == CH_PLUS) begin
					neg_c   = (req_s1.ch == CH_MINUS);
					idx_c   = (idx_c == OFFSET_MAX) ? idx_c : idx_c + 1'b1;
					phase_c = PH_SIGNED;
				end else begin
					lead = 1'b1;
				end
			end
			PH_SIGNED: lead = 1'b1;
			PH_ZERO: begin
				if (req_s1.ch == CH_LX || req_s1.ch == CH_UX) begin
					base_c  = RADIX_HEX;
					phase_c = PH_XSEEN;
				end else begin
					if (base_c == RADIX_AUTO)
						base_c = RADIX_OCT;
					phase_c = PH_DIGITS;
					take    = 1'b1;
				end
			end
			PH_XSEEN: begin
				if (dval < RADIX_HEX) begin
					idx_c   = (idx_c == OFFSET_MAX) ? idx_c : idx_c + 1'b1;
					phase_c = PH_DIGITS;
					take    = 1'b1;
				end else begin
					emit    = 1'b1;
					phase_c = PH_IDLE;
				end
			end
			PH_DIGITS: take = 1'b1;
			default: ;
		endcase

		if (lead) begin
			if (req_s1.ch == CH_ZERO && (base_c == RADIX_AUTO || base_c == RADIX_HEX)) begin
				digit_c = 1'b1;
				idx_c   = (idx_c == OFFSET_MAX) ? idx_c : idx_c + 1'b1;
				phase_c = PH_ZERO;
			end else begin
				if (base_c == RADIX_AUTO)
					base_c = RADIX_DEC;
				phase_c = PH_DIGITS;
				take    = 1'b1;
			end
		end

		if (take) begin
			take_ok = (base_c >= RADIX_MIN) && (base_c <= RADIX_MAX) && (dval < base_c);
			prod = WIDE_BITS'(acc_c) * WIDE_BITS'(base_c) + WIDE_BITS'(dval);
			if (take_ok) begin
				if (ovf_c || prod[WIDE_BITS-1:WORD_BITS] != '0)
					ovf_c = 1'b1;
				else
					acc_c = prod[WORD_BITS-1:0];
				digit_c = 1'b1;
				idx_c   = (idx_c == OFFSET_MAX) ? idx_c : idx_c + 1'b1;
			end else begin
				emit    = 1'b1;
				phase_c = PH_IDLE;
			end
		end
	end

	// result fields
	always_comb begin
		if (ovf_c)
			res_c.value = '1;
		else if (neg_c)
			res_c.value = WORD_BITS'(0) - acc_c;
		else
			res_c.value = acc_c;
		res_c.overflow    = ovf_c;
		res_c.stop_offset = digit_c ? idx_c : '0;
		res_c.any_digit   = digit_c;
	end

	assign go       = valid_s1 && (!emit || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			req_s1 <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			base_q  <= '0;
			neg_q   <= 1'b0;
			digit_q <= 1'b0;
			ovf_q   <= 1'b0;
			idx_q   <= '0;
		end else if (go) begin
			phase_q <= phase_c;
			acc_q   <= acc_c;
			base_q  <= base_c;
			neg_q   <= neg_c;
			digit_q <= digit_c;
			ovf_q   <= ovf_c;
			idx_q   <= idx_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit)
			out_req_q <= res_c;
	end

	assign out_valid = out_valid_q;
	assign out_req   = out_req_q;

	`A2U_ASSERT_NOW(a_no_overwrite, clk, arst_n, go && emit, !(out_valid_q && out_stall))
	`A2U_ASSERT_NEXT(a_idle_after_result, clk, arst_n, go && emit, phase_q == PH_IDLE)
	`A2U_ASSERT_NOW(a_ovf_all_ones, clk, arst_n, out_valid && out_req.overflow,
		out_req.value == '1)
	`A2U_ASSERT_NOW(a_no_digit_empty, clk, arst_n, out_valid && !out_req.any_digit,
		out_req.stop_offset == '0 && out_req.value == '0 && !out_req.overflow)

endmodule
